// File: hdl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
package fpa_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_BITS  = 8;
    localparam int DVD_W      = WORD_W + FRAC_BITS;
    localparam int DIV_STEPS  = DVD_W;
    localparam int MODE_W     = 4;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_LT     = 4'd4,
        MODE_LE     = 4'd5,
        MODE_GT     = 4'd6,
        MODE_GE     = 4'd7,
        MODE_EQ     = 4'd8,
        MODE_NE     = 4'd9,
        MODE_MIN    = 4'd10,
        MODE_MAX    = 4'd11,
        MODE_INC    = 4'd12,
        MODE_DEC    = 4'd13,
        MODE_TO_INT = 4'd14
    } fpa_mode_t;

    // Side result of the non-divide ops plus the divide flags, riding alongside the divider.
    typedef struct packed {
        logic              is_div;
        logic [WORD_W-1:0] res;
        logic              cmp;
        logic              dz;
        logic              qneg;
    } fpa_side_t;

endpackage

// File: hdl/fpa_divider.sv
// Pipelined radix-2 restoring divider, one quotient bit per stage.
module fpa_divider (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  fpa_pkg::fpa_side_t        in_side,
    input  logic [fpa_pkg::DVD_W-1:0] in_dividend,
    input  logic [fpa_pkg::WORD_W-1:0] in_divisor,
    output logic                      out_valid,
    output fpa_pkg::fpa_side_t        out_side,
    output logic [fpa_pkg::WORD_W-1:0] out_quot
);
    import fpa_pkg::*;

    logic [WORD_W-1:0] rem_reg  [DIV_STEPS];
    logic [DVD_W-1:0]  dvd_reg  [DIV_STEPS];
    logic [WORD_W-1:0] dvs_reg  [DIV_STEPS];
    fpa_side_t         side_reg [DIV_STEPS];
    logic              vld_reg  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [WORD_W-1:0] p_rem;
        logic [DVD_W-1:0]  p_dvd;
        logic [WORD_W-1:0] p_dvs;
        fpa_side_t         p_side;
        logic              p_vld;
        logic [WORD_W:0]   trial;
        logic [WORD_W:0]   diff;
        logic              ge;
        logic [WORD_W-1:0] rem_next;
        logic [DVD_W-1:0]  dvd_next;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_dvd  = in_dividend;
            assign p_dvs  = in_divisor;
            assign p_side = in_side;
            assign p_vld  = in_valid;
        end else begin : g_rest
            assign p_rem  = rem_reg[k-1];
            assign p_dvd  = dvd_reg[k-1];
            assign p_dvs  = dvs_reg[k-1];
            assign p_side = side_reg[k-1];
            assign p_vld  = vld_reg[k-1];
        end

        always_comb
        begin
            trial    = {p_rem, p_dvd[DVD_W-1]};
            diff     = trial - {1'b0, p_dvs};
            ge       = (trial >= {1'b0, p_dvs});
            rem_next = ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
            // quotient bits shift in where dividend bits leave
            dvd_next = {p_dvd[DVD_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= p_vld;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                dvd_reg[k]  <= dvd_next;
                dvs_reg[k]  <= p_dvs;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];
    assign out_quot  = dvd_reg[DIV_STEPS-1][WORD_W-1:0];

    a_divisor_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.dz |-> out_side.is_div)
        else $error("divide-by-zero flag on a non-divide beat");

    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_side.dz |-> out_side.res == '0)
        else $error("divide-by-zero beat carries a nonzero side result");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_side.dz && out_side.cmp))
        else $error("compare and divide-by-zero both set");

endmodule

// File: hdl/fixed_point_alu_core.sv
// Top level of the signed Q24.8 fixed-point ALU.
// Fully pipelined fixed-point ALU on 32-bit raw words with 8 fraction bits:
// one beat is accepted every cycle while the output is not stalled, and every
// result passes through 43 register stages (an input register, an operand
// stage with the 32x32 multiplier, the 40-stage radix-2 divider pipeline and
// the output register); the divider's one-quotient-bit-per-stage chain sets
// that depth for every mode so results stay in order. A stall on the output
// freezes the whole pipeline and loses nothing.
module fixed_point_alu_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fpa_pkg::IN_DATA_W-1:0]   s_tdata,  // operand_a, operand_b
    input  logic [fpa_pkg::MODE_W-1:0]      s_tuser,  // mode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fpa_pkg::OUT_DATA_W-1:0]  m_tdata   // result, compare_true,
                                                      // divide_by_zero, zero pad
);
    import fpa_pkg::*;

    logic advance;

    // stage 1: input register
    logic                     v1_reg;
    fpa_mode_t                mode1_reg;
    logic signed [WORD_W-1:0] a1_reg;
    logic signed [WORD_W-1:0] b1_reg;

    // stage 2: simple ops, product, divider setup
    logic                       v2_reg;
    logic                       mul2_reg;
    fpa_side_t                  side2_reg;
    logic signed [2*WORD_W-1:0] prod2_reg;
    logic [DVD_W-1:0]           dvd2_reg;
    logic [WORD_W-1:0]          dvs2_reg;

    fpa_side_t                  side2_next;
    logic [WORD_W-1:0]          abs_a;
    logic [WORD_W-1:0]          abs_b;
    logic signed [WORD_W-1:0]   to_int_val;
    logic                       lt;
    logic                       eq;

    fpa_side_t                  div_side_in;
    logic signed [2*WORD_W-1:0] prod_adj;

    logic                       dv_valid;
    fpa_side_t                  dv_side;
    logic [WORD_W-1:0]          dv_quot;

    logic                       m_tvalid_reg;
    logic [WORD_W-1:0]          result_reg;
    logic                       cmp_reg;
    logic                       dz_reg;
    logic [WORD_W-1:0]          result_next;

    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mode1_reg <= fpa_mode_t'(s_tuser);
            a1_reg    <= s_tdata[WORD_W-1:0];
            b1_reg    <= s_tdata[2*WORD_W-1:WORD_W];
        end
    end

    always_comb
    begin
        abs_a      = a1_reg[WORD_W-1] ? WORD_W'(-a1_reg) : WORD_W'(a1_reg);
        abs_b      = b1_reg[WORD_W-1] ? WORD_W'(-b1_reg) : WORD_W'(b1_reg);
        lt         = (a1_reg < b1_reg);
        eq         = (a1_reg == b1_reg);
        // bias negatives so the arithmetic shift truncates toward zero
        to_int_val = $signed(a1_reg + (a1_reg[WORD_W-1] ? WORD_W'((1 << FRAC_BITS) - 1)
                                                        : WORD_W'(0)))
                     >>> FRAC_BITS;

        side2_next        = '0;
        side2_next.qneg   = a1_reg[WORD_W-1] ^ b1_reg[WORD_W-1];
        unique case (mode1_reg)
            MODE_ADD:    side2_next.res = a1_reg + b1_reg;
            MODE_SUB:    side2_next.res = a1_reg - b1_reg;
            MODE_MUL:    side2_next.res = '0;
            MODE_DIV:
            begin
                side2_next.is_div = 1'b1;
                side2_next.dz     = (b1_reg == '0);
            end
            MODE_LT:     side2_next.cmp = lt;
            MODE_LE:     side2_next.cmp = lt || eq;
            MODE_GT:     side2_next.cmp = !(lt || eq);
            MODE_GE:     side2_next.cmp = !lt;
            MODE_EQ:     side2_next.cmp = eq;
            MODE_NE:     side2_next.cmp = !eq;
            MODE_MIN:    side2_next.res = (lt || eq) ? a1_reg : b1_reg;
            MODE_MAX:    side2_next.res = (lt || eq) ? b1_reg : a1_reg;
            MODE_INC:    side2_next.res = a1_reg + WORD_W'(1);
            MODE_DEC:    side2_next.res = a1_reg - WORD_W'(1);
            MODE_TO_INT: side2_next.res = to_int_val;
            default:     side2_next.res = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            side2_reg <= side2_next;
            mul2_reg  <= (mode1_reg == MODE_MUL);
            prod2_reg <= (2*WORD_W)'(a1_reg) * (2*WORD_W)'(b1_reg);
            dvd2_reg  <= {abs_a, {FRAC_BITS{1'b0}}};
            dvs2_reg  <= abs_b;
        end
    end

    // multiply fixup: truncate the product toward zero, then wrap
    always_comb
    begin
        prod_adj = (prod2_reg + (prod2_reg[2*WORD_W-1]
                   ? (2*WORD_W)'((1 << FRAC_BITS) - 1) : '0)) >>> FRAC_BITS;
        div_side_in = side2_reg;
        if (mul2_reg)
        begin
            div_side_in.res = prod_adj[WORD_W-1:0];
        end
    end

    fpa_divider u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (advance),
        .in_valid    (v2_reg),
        .in_side     (div_side_in),
        .in_dividend (dvd2_reg),
        .in_divisor  (dvs2_reg),
        .out_valid   (dv_valid),
        .out_side    (dv_side),
        .out_quot    (dv_quot)
    );

    always_comb
    begin
        result_next = dv_side.res;
        if (dv_side.is_div && !dv_side.dz)
        begin
            result_next = dv_side.qneg ? (~dv_quot + WORD_W'(1)) : dv_quot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
            cmp_reg    <= dv_side.cmp;
            dz_reg     <= dv_side.dz;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-WORD_W-2){1'b0}}, dz_reg, cmp_reg, result_reg};

    a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && dz_reg |-> result_reg == '0)
        else $error("divide-by-zero beat with nonzero result");

    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped during stall");

    a_ready_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without an output stall");

    a_cmp_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && cmp_reg |-> result_reg == '0)
        else $error("compare beat with nonzero result");

endmodule
